### rtl/piecewise_linear_table_interp_defines.svh
// Assertion macros for the piecewise linear interpolation block.
// Define NO_ASSERTIONS to compile them away.
`ifndef PIECEWISE_LINEAR_TABLE_INTERP_DEFINES_SVH
`define PIECEWISE_LINEAR_TABLE_INTERP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PLTI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PLTI_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLTI_ASSERT(label, clk, rst, prop, msg)
`define PLTI_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### rtl/plti_pkg.sv
// Shared types and constants of the piecewise linear interpolation block.
// No dependencies.
`default_nettype none
package plti_pkg;
   localparam int TableDepth = 64;
   localparam int IdxW = 6;
   localparam int DataW = 32;
   localparam int LenW = 7;
   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_VALUE = 2'd1;
   localparam logic [1:0] MODE_SLOPE = 2'd2;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EQUAL = 2'd1;
   localparam logic [1:0] ST_LOADED = 2'd2;
   localparam logic [0:0] REG_TABLE_LENGTH = 1'd0;
   // divider control between the top and the divider
   typedef struct packed {
      logic start;
      logic [48:0] num;
      logic [32:0] den;
   } div_req_type;
   typedef struct packed {
      logic done;
      logic signed [31:0] quot;
   } div_rsp_type;
endpackage
`default_nettype wire

### rtl/plti_if.sv
// Valid/ready channel interfaces for requests and results.
// No dependencies.
`default_nettype none
interface plti_req_if;
   logic valid;
   logic ready;
   logic [1:0] mode;
   logic [5:0] entry_index;
   logic signed [31:0] x_value;
   logic signed [31:0] y_value;
   modport source (output valid, mode, entry_index, x_value, y_value, input ready);
   modport sink (input valid, mode, entry_index, x_value, y_value, output ready);
endinterface

interface plti_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] result_value;
   logic [5:0] segment;
   logic [1:0] status;
   modport source (output valid, result_value, segment, status, input ready);
   modport sink (input valid, result_value, segment, status, output ready);
endinterface
`default_nettype wire

### rtl/plti_div.sv
// Restoring serial divider: signed 49-bit numerator by 33-bit divisor,
// truncated quotient saturated to 32 bits. Depends on plti_pkg.
`default_nettype none
module plti_div (
   input wire logic clock,
   input wire logic reset,
   input wire plti_pkg::div_req_type req,
   output plti_pkg::div_rsp_type rsp
);
   logic [48:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] den_ff, den_in;
   logic neg_ff, neg_in;
   logic busy_ff, busy_in;
   logic [5:0] cnt_ff, cnt_in;
   logic done_ff, done_in;
   logic [33:0] trial;
   logic [33:0] diff;
   logic [48:0] q_sat;

   assign trial = {rem_ff, quo_ff[48]};
   assign diff = trial - {1'b0, den_ff};

   // saturation of the final magnitude
   always_comb begin
      rsp.done = done_ff;
      if (neg_ff) begin
         q_sat = (quo_ff > 49'h80000000) ? 49'h80000000 : quo_ff;
         rsp.quot = 32'(49'd0 - q_sat);
      end else begin
         q_sat = (quo_ff > 49'h7FFFFFFF) ? 49'h7FFFFFFF : quo_ff;
         rsp.quot = q_sat[31:0];
      end
   end

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; den_in = den_ff; neg_in = neg_ff;
      busy_in = busy_ff; cnt_in = cnt_ff; done_in = 1'b0;
      if (req.start) begin
         quo_in = req.num[48] ? 49'd0 - req.num : req.num;
         den_in = req.den[32] ? 33'd0 - req.den : req.den;
         neg_in = req.num[48] ^ req.den[32];
         rem_in = '0; busy_in = 1'b1; cnt_in = '0;
      end else if (busy_ff) begin
         // one quotient bit a cycle
         if (!diff[33]) begin
            rem_in = diff[32:0]; quo_in = {quo_ff[47:0], 1'b1};
         end else begin
            rem_in = trial[32:0]; quo_in = {quo_ff[47:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd48) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in; neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end
endmodule
`default_nettype wire

### rtl/piecewise_linear_table_interp.sv
// Piecewise linear table interpolation, top level; uses plti_pkg, plti_if, plti_div.
// Request to result transfer: a load or unused mode goes straight to the result;
// an evaluate searches in at most 6 steps, reads the segment, then on equal
// breakpoints ends there, else divides serially; a value also multiplies.
// Throughput: one item at a time; next request taken the cycle after the result.
// Synchronous active-high reset: table_length 2, no result pending; table undefined.
`default_nettype none
`include "piecewise_linear_table_interp_defines.svh"
module piecewise_linear_table_interp (
   input wire logic clock,
   input wire logic reset,
   plti_req_if.sink req,
   plti_rsp_if.source rsp,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [2:0] csr_paddr,
   input wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   typedef enum logic [3:0] {
      S_IDLE, S_LEN0, S_LEN1, S_SRCH_RD, S_SRCH_CMP, S_RD_X0, S_RD_X1,
      S_RD_Y0, S_RD_Y1, S_DIV, S_MUL, S_OUT
   } state_type;

   // one entry per word: x in low, y in high
   logic [63:0] mem [plti_pkg::TableDepth];
   logic [63:0] rd_ff;
   logic [5:0] raddr;
   logic wen;

   state_type state_ff, state_in;
   logic [6:0] len_reg_ff;
   logic [1:0] mode_ff;
   logic signed [31:0] xq_ff;
   logic [5:0] jl_ff, ju_ff, jl_in, ju_in, len_m1;
   logic asc_ff;
   logic signed [31:0] x0_ff, x1_ff, y0_ff;
   logic signed [32:0] dy_ff;
   logic signed [65:0] prod_ff;
   logic signed [31:0] res_ff;
   logic [1:0] st_ff;
   logic rvalid_ff;
   plti_pkg::div_req_type dreq;
   plti_pkg::div_rsp_type drsp;
   logic [5:0] jm;
   logic signed [49:0] sum;

   // effective table length minus one, clamped to 1..63
   always_comb begin
      if (len_reg_ff < 7'd2) len_m1 = 6'd1;
      else if (len_reg_ff > 7'd64) len_m1 = 6'd63;
      else len_m1 = 6'(len_reg_ff - 7'd1);
   end
   assign jm = 6'((7'(jl_ff) + 7'(ju_ff)) >> 1);

   // config port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == plti_pkg::REG_TABLE_LENGTH)
      ? {25'd0, len_reg_ff} : 32'd0;

   assign req.ready = (state_ff == S_IDLE) && !rvalid_ff;
   assign rsp.valid = rvalid_ff;
   assign rsp.result_value = res_ff;
   assign rsp.segment = jl_ff;
   assign rsp.status = st_ff;

   // table memory port
   assign wen = req.valid && req.ready && req.mode == plti_pkg::MODE_LOAD;
   always_comb begin
      case (state_ff)
         S_IDLE: raddr = len_m1;
         S_LEN0: raddr = 6'd0;
         S_SRCH_RD: raddr = jm;
         S_RD_X1: raddr = jl_ff + 6'd1;
         default: raddr = jl_ff;
      endcase
   end
   always_ff @(posedge clock) begin
      if (wen) mem[req.entry_index] <= {req.y_value, req.x_value};
      rd_ff <= mem[raddr];
   end

   assign dreq.start = (state_ff == S_RD_Y1) && (x0_ff != x1_ff);
   assign dreq.den = 33'(x1_ff) - 33'(x0_ff);
   assign dreq.num = (mode_ff == plti_pkg::MODE_SLOPE)
      ? {dy_ff, 16'd0}
      : {33'(xq_ff) - 33'(x0_ff), 16'd0};

   plti_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // floor(f*dy/2^16) + y0 saturated
   assign sum = 50'(prod_ff >>> 16) + 50'(y0_ff);

   always_comb begin
      state_in = state_ff; jl_in = jl_ff; ju_in = ju_ff;
      case (state_ff)
         S_IDLE: if (req.valid && req.ready) begin
            jl_in = 6'd0;
            if (req.mode == plti_pkg::MODE_VALUE || req.mode == plti_pkg::MODE_SLOPE)
               state_in = S_LEN0;
            else state_in = S_OUT;
         end
         S_LEN0: state_in = S_LEN1;
         S_LEN1: begin
            jl_in = 6'd0; ju_in = len_m1;
            state_in = (len_m1 > 6'd1) ? S_SRCH_RD : S_RD_X0;
         end
         S_SRCH_RD: state_in = S_SRCH_CMP;
         S_SRCH_CMP: begin
            if (($signed(xq_ff) >= $signed(rd_ff[31:0])) == asc_ff) jl_in = jm;
            else ju_in = jm;
            if (((ju_in - jl_in) > 6'd1)) state_in = S_SRCH_RD;
            else state_in = S_RD_X0;
         end
         S_RD_X0: state_in = S_RD_X1;
         S_RD_X1: state_in = S_RD_Y0;
         S_RD_Y0: state_in = S_RD_Y1;
         S_RD_Y1: state_in = (x0_ff == x1_ff) ? S_OUT : S_DIV;
         S_DIV: if (drsp.done)
            state_in = (mode_ff == plti_pkg::MODE_SLOPE) ? S_OUT : S_MUL;
         S_MUL: state_in = S_OUT;
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      // a new transfer clears the result value and sets the status for its mode
      if (req.valid && req.ready) begin
         mode_ff <= req.mode; xq_ff <= req.x_value;
         res_ff <= '0;
         st_ff <= (req.mode == plti_pkg::MODE_LOAD) ? plti_pkg::ST_LOADED
                                                    : plti_pkg::ST_OK;
      end
      jl_ff <= jl_in; ju_ff <= ju_in;
      case (state_ff)
         S_LEN1: asc_ff <= $signed(x1_ff) >= $signed(rd_ff[31:0]);
         S_LEN0: x1_ff <= rd_ff[31:0];
         S_RD_X1: begin x0_ff <= rd_ff[31:0]; y0_ff <= rd_ff[63:32]; end
         S_RD_Y0: begin
            x1_ff <= rd_ff[31:0];
            dy_ff <= 33'($signed(rd_ff[63:32])) - 33'(y0_ff);
         end
         S_DIV: if (drsp.done) begin
            res_ff <= $signed(drsp.quot);
            prod_ff <= 66'($signed(drsp.quot)) * 66'(dy_ff);
         end
         S_MUL: begin
            if (sum > 50'sh7FFFFFFF) res_ff <= 32'sh7FFFFFFF;
            else if (sum < -50'sh80000000) res_ff <= 32'sh80000000;
            else res_ff <= sum[31:0];
         end
         default: ;
      endcase
      if (state_ff == S_RD_Y1 && x0_ff == x1_ff) st_ff <= plti_pkg::ST_EQUAL;
      if (reset) begin
         state_ff <= S_IDLE; rvalid_ff <= 1'b0; len_reg_ff <= 7'd2;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_OUT) rvalid_ff <= 1'b1;
         else if (rsp.ready) rvalid_ff <= 1'b0;
         if (csr_psel && csr_penable && csr_pwrite
             && csr_paddr[2] == plti_pkg::REG_TABLE_LENGTH)
            len_reg_ff <= csr_pwdata[6:0];
      end
   end

   `PLTI_ASSERT(a_busy, clock, reset, (state_ff != S_IDLE) |-> !req.ready, "accept while busy")
   `PLTI_ASSERT(a_seg_range, clock, reset, rvalid_ff |-> (jl_ff <= 6'd62), "segment out of range")
   `PLTI_ASSERT(a_out_once, clock, reset, (state_ff == S_OUT) |=> rvalid_ff, "result lost")
endmodule
`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for the piecewise linear table interpolation block.
// Depends on plti_pkg, plti_if and the block's RTL; drives loads, queries and
// table-length writes, and checks every result against its predictor or the row's expected result.
`timescale 1ns / 100ps
module testbench;
   localparam int DEPTH = plti_pkg::TableDepth;
   localparam logic [1:0] M_LD = plti_pkg::MODE_LOAD;
   localparam logic [1:0] M_VAL = plti_pkg::MODE_VALUE;
   localparam logic [1:0] M_SLP = plti_pkg::MODE_SLOPE;
   localparam logic [1:0] M_UNUSED = 2'd3;
   localparam logic [1:0] S_OK = plti_pkg::ST_OK;
   localparam logic [1:0] S_EQ = plti_pkg::ST_EQUAL;
   localparam logic [1:0] S_LD = plti_pkg::ST_LOADED;

   typedef struct {
      logic [1:0] mode;
      logic [5:0] idx;
      logic signed [31:0] x;
      logic signed [31:0] y;
      bit typed;                    // expected result given in the row
      logic signed [31:0] t_val;
      logic [5:0] t_seg;
      logic [1:0] t_st;
   } item_type;

   typedef struct {
      logic signed [31:0] val;
      logic [5:0] seg;
      logic [1:0] st;
   } interp_res_type;

   localparam longint QMAX = 64'sd2147483647;
   localparam longint QMIN = -64'sd2147483648;
   localparam int IDLE_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   plti_req_if req_ch ();
   plti_rsp_if rsp_ch ();

   piecewise_linear_table_interp u_dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic signed [31:0] bp_store [DEPTH];
   logic signed [31:0] val_store [DEPTH];
   logic [plti_pkg::LenW-1:0] len_reg = 7'd2;
   interp_res_type expected_q [$];
   item_type offer;
   int fail_count = 0;
   int req_count = 0;
   int idle_cycles = 0;
   bit no_idle = 0;

   function automatic longint sat_quot(longint num, longint den);
      longint unsigned q;
      bit neg;
      q = longint'(num < 0 ? -num : num) / longint'(den < 0 ? -den : den);
      neg = (num < 0) != (den < 0);
      if (neg) begin
         if (q > 64'd2147483648) q = 64'd2147483648;
         return -longint'(q);
      end
      if (q > 64'd2147483647) q = 64'd2147483647;
      return longint'(q);
   endfunction

   // expected result of one transfer; loads update the table copy
   function automatic interp_res_type predict_interp(item_type it);
      interp_res_type r;
      int len, lo, hi, mid;
      bit ascending;
      longint xq, x0, x1, y0, y1, h, dy, f, acc;
      r.val = '0; r.seg = '0; r.st = S_OK;
      if (it.mode == M_LD) begin
         bp_store[it.idx] = it.x;
         val_store[it.idx] = it.y;
         r.st = S_LD;
         return r;
      end
      if (it.mode != M_VAL && it.mode != M_SLP) return r;
      len = len_reg;
      if (len < 2) len = 2;
      if (len > DEPTH) len = DEPTH;
      xq = it.x;
      ascending = bp_store[len-1] >= bp_store[0];
      lo = 0; hi = len - 1;
      while (hi - lo > 1) begin
         mid = (hi + lo) / 2;
         if ((xq >= longint'(bp_store[mid])) == ascending) lo = mid;
         else hi = mid;
      end
      if (lo > len - 2) lo = len - 2;
      r.seg = lo[5:0];
      x0 = bp_store[lo]; x1 = bp_store[lo+1];
      y0 = val_store[lo]; y1 = val_store[lo+1];
      if (x0 == x1) begin
         r.st = S_EQ;
         return r;
      end
      h = x1 - x0;
      dy = y1 - y0;
      if (it.mode == M_SLP) acc = sat_quot(dy * 65536, h);
      else begin
         f = sat_quot((xq - x0) * 65536, h);
         acc = y0 + ((f * dy) >>> 16);
         if (acc > QMAX) acc = QMAX;
         if (acc < QMIN) acc = QMIN;
      end
      r.val = acc[31:0];
      return r;
   endfunction

   // monitor: predict on request transfers, check on result transfers
   always @(posedge clock) begin
      interp_res_type exp_r;
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
         if (req_ch.valid && req_ch.ready) begin
            exp_r = predict_interp(offer);
            if (offer.typed) begin
               exp_r.val = offer.t_val; exp_r.seg = offer.t_seg; exp_r.st = offer.t_st;
            end
            expected_q.push_back(exp_r);
            req_count <= req_count + 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
               $error("result transfer with nothing expected");
               fail_count++;
            end else begin
               exp_r = expected_q.pop_front();
               if (rsp_ch.result_value !== exp_r.val) begin
                  $error("result_value expected %h got %h", exp_r.val, rsp_ch.result_value);
                  fail_count++;
               end
               if (rsp_ch.segment !== exp_r.seg) begin
                  $error("segment expected %0d got %0d", exp_r.seg, rsp_ch.segment);
                  fail_count++;
               end
               if (rsp_ch.status !== exp_r.st) begin
                  $error("status expected %0d got %0d", exp_r.st, rsp_ch.status);
                  fail_count++;
               end
            end
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side: random stalls, one long hold-off while the sender keeps going
   initial begin
      bit held;
      int n;
      held = 0;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && req_count > 700) begin
            held = 1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         n = pick_gap();
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   // one request transfer; called at a falling edge, returns at one
   task automatic send_item(item_type it);
      int n;
      n = pick_gap();
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      offer <= it;
      req_ch.mode <= it.mode;
      req_ch.entry_index <= it.idx;
      req_ch.x_value <= it.x;
      req_ch.y_value <= it.y;
      req_ch.valid <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_plain(logic [1:0] mode, logic [5:0] idx, logic [31:0] x,
                             logic [31:0] y);
      item_type it;
      it = '{mode, idx, x, y, 1'b0, '0, '0, '0};
      send_item(it);
   endtask

   // wait for every result, then let the block settle before a register write
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_length(logic [31:0] value);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= 3'(plti_pkg::REG_TABLE_LENGTH * 4);
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      len_reg = value[plti_pkg::LenW-1:0];
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   // load a table: 0 ascending, 1 descending, 2 ascending with a repeat, 3 noise
   task automatic load_table(int kind, int len);
      longint xs [DEPTH];
      longint pos, max_step, y;
      int i, dup;
      max_step = ($urandom_range(0, 3) == 0) ? 256 : (64'sd2147483647 / len);
      pos = -(longint'($urandom_range(0, 32'h3FFF_FFFF)));
      if (len == 2 && $urandom_range(0, 1)) pos = QMIN;
      for (i = 0; i < len; i++) begin
         xs[i] = pos;
         pos = pos + $urandom_range(1, 32'(max_step));
         if (pos > QMAX) pos = QMAX;
      end
      if (kind == 2) begin
         dup = $urandom_range(0, len - 2);
         xs[dup+1] = xs[dup];
      end
      y = $signed($urandom);
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 2) == 0) y = $signed($urandom);
         else y = y + $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0001_FFFF;
         if (y > QMAX) y = QMAX;
         if (y < QMIN) y = QMIN;
         if (kind == 3)
            send_plain(M_LD, 6'(i), $urandom, $urandom);
         else if (kind == 1)
            send_plain(M_LD, 6'(i), 32'(xs[len-1-i]), 32'(y));
         else
            send_plain(M_LD, 6'(i), 32'(xs[i]), 32'(y));
      end
   endtask

   task automatic random_queries(int count, int len);
      int k, r, i;
      longint a, b, lo, hi, x;
      for (i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         k = $urandom_range(0, len - 2);
         a = bp_store[k]; b = bp_store[k+1];
         lo = (a < b) ? a : b;
         hi = (a < b) ? b : a;
         x = lo + ($urandom % (hi - lo + 1));
         if (r < 10) x = $signed($urandom);
         else if (r < 14) x = bp_store[$urandom_range(0, len - 1)];
         r = $urandom_range(0, 99);
         if (r < 46) send_plain(M_VAL, 6'($urandom), 32'(x), $urandom);
         else if (r < 92) send_plain(M_SLP, 6'($urandom), 32'(x), $urandom);
         else if (r < 95) send_plain(M_UNUSED, 6'($urandom), $urandom, $urandom);
         else send_plain(M_LD, 6'($urandom), $urandom, $urandom);
      end
   endtask

   // directed rows; expected values only where they are obvious
   item_type directed [] = '{
      '{M_LD, 6'd0, 32'sh0, 32'sh0, 1, 32'sh0, 6'd0, S_LD},
      '{M_LD, 6'd1, 32'sh0001_0000, 32'sh0001_0000, 1, 32'sh0, 6'd0, S_LD},
      '{M_SLP, 6'd0, 32'sh0000_8000, 32'sh0, 1, 32'sh0001_0000, 6'd0, S_OK},
      '{M_VAL, 6'd0, 32'sh0000_8000, 32'sh0, 1, 32'sh0000_8000, 6'd0, S_OK},
      '{M_VAL, 6'd0, 32'sh8000_0000, 32'sh0, 0, 32'sh0, 6'd0, S_OK},
      '{M_VAL, 6'd0, 32'sh7FFF_FFFF, 32'sh0, 0, 32'sh0, 6'd0, S_OK},
      '{M_UNUSED, 6'd63, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 1, 32'sh0, 6'd0, S_OK},
      '{M_LD, 6'd1, 32'sh0, 32'sh7FFF_FFFF, 1, 32'sh0, 6'd0, S_LD},
      '{M_VAL, 6'd0, 32'sh1234, 32'sh0, 1, 32'sh0, 6'd0, S_EQ},
      '{M_SLP, 6'd0, 32'sh0, 32'sh0, 1, 32'sh0, 6'd0, S_EQ},
      // steepest rise and fall saturate the slope
      '{M_LD, 6'd0, 32'sh0, 32'sh8000_0000, 1, 32'sh0, 6'd0, S_LD},
      '{M_LD, 6'd1, 32'sh1, 32'sh7FFF_FFFF, 1, 32'sh0, 6'd0, S_LD},
      '{M_SLP, 6'd0, 32'sh0, 32'sh0, 1, 32'sh7FFF_FFFF, 6'd0, S_OK},
      '{M_VAL, 6'd0, 32'sh7FFF_FFFF, 32'sh0, 1, 32'sh7FFF_FFFF, 6'd0, S_OK},
      '{M_VAL, 6'd0, 32'sh8000_0000, 32'sh0, 1, 32'sh8000_0000, 6'd0, S_OK},
      '{M_LD, 6'd1, 32'sh1, 32'sh8000_0000, 1, 32'sh0, 6'd0, S_LD},
      '{M_LD, 6'd0, 32'sh0, 32'sh7FFF_FFFF, 1, 32'sh0, 6'd0, S_LD},
      '{M_SLP, 6'd0, 32'sh0, 32'sh0, 1, 32'sh8000_0000, 6'd0, S_OK},
      // widest span, then a descending pair
      '{M_LD, 6'd0, 32'sh8000_0000, 32'sh8000_0000, 1, 32'sh0, 6'd0, S_LD},
      '{M_LD, 6'd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 32'sh0, 6'd0, S_LD},
      '{M_VAL, 6'd0, 32'sh0, 32'sh0, 0, 32'sh0, 6'd0, S_OK},
      '{M_SLP, 6'd0, 32'sh0, 32'sh0, 0, 32'sh0, 6'd0, S_OK},
      '{M_LD, 6'd0, 32'sh0064_0000, 32'shFFF0_0000, 1, 32'sh0, 6'd0, S_LD},
      '{M_LD, 6'd1, 32'shFF9C_0000, 32'sh0010_0000, 1, 32'sh0, 6'd0, S_LD},
      '{M_VAL, 6'd0, 32'sh0200_0000, 32'sh0, 0, 32'sh0, 6'd0, S_OK}
   };

   // main sequence
   initial begin
      int lengths [] = '{2, 64, 0, 1, 127, 65, 3, 17, 33, 63, 5, 40};
      int i, len;
      req_ch.valid = 1'b0;
      req_ch.mode = M_LD;
      req_ch.entry_index = '0;
      req_ch.x_value = '0;
      req_ch.y_value = '0;
      offer = '{M_LD, '0, '0, '0, 1'b0, '0, '0, '0};
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // every entry written before any longer table is searched
      for (i = 0; i < DEPTH; i++) send_plain(M_LD, 6'(i), $urandom, $urandom);
      foreach (directed[i]) send_item(directed[i]);

      foreach (lengths[i]) begin
         drain();
         write_length(lengths[i]);
         len = lengths[i];
         if (len < 2) len = 2;
         if (len > DEPTH) len = DEPTH;
         no_idle = (i % 4 == 3);
         load_table($urandom_range(0, 9) < 6 ? $urandom_range(0, 1)
                                              : $urandom_range(2, 3), len);
         random_queries(len > 16 ? 70 : 90, len);
      end
      drain();
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
